/* design/stl_pkg.sv */
package stl_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int NUM_KEYWORDS    = 10;

  localparam logic [5:0] KIND_NONE     = 6'd0;
  localparam logic [5:0] KIND_NUMBER   = 6'd22;
  localparam logic [5:0] KIND_STRING   = 6'd23;
  localparam logic [5:0] KIND_IDENT    = 6'd24;
  localparam logic [5:0] KIND_KEYWORD0 = 6'd25;
  localparam logic [5:0] KIND_LBRACKET = 6'd35;
  localparam logic [5:0] KIND_RBRACKET = 6'd36;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

  // keywords, big-endian, first character in the highest used byte
  localparam logic [63:0] KEYWORDS [NUM_KEYWORDS] = '{
    64'h0000_0000_0000_6966,  // if
    64'h0000_0000_656c_7365,  // else
    64'h0000_0077_6869_6c65,  // while
    64'h0000_0000_0066_6f72,  // for
    64'h0000_0000_0000_646f,  // do
    64'h0000_0062_7265_616b,  // break
    64'h636f_6e74_696e_7565,  // continue
    64'h0000_7265_7475_726e,  // return
    64'h0000_0000_7472_7565,  // true
    64'h0000_0066_616c_7365   // false
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [1:0]  err;
    logic        last;
  } result_t;

  // everything one source word produces
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } match_t;

  function automatic match_t punct_match(logic [7:0] b);
    match_t m;
    m.hit = 1'b1;
    unique case (b)
      8'h2b:   m.kind = 6'd0;   // +
      8'h2d:   m.kind = 6'd1;   // -
      8'h2a:   m.kind = 6'd2;   // *
      8'h2f:   m.kind = 6'd3;   // /
      8'h25:   m.kind = 6'd4;   // %
      8'h3d:   m.kind = 6'd5;   // =
      8'h21:   m.kind = 6'd6;   // !
      8'h3c:   m.kind = 6'd7;   // <
      8'h3e:   m.kind = 6'd8;   // >
      8'h26:   m.kind = 6'd9;   // &
      8'h7c:   m.kind = 6'd10;  // |
      8'h5e:   m.kind = 6'd11;  // ^
      8'h7e:   m.kind = 6'd12;  // ~
      8'h3f:   m.kind = 6'd13;  // ?
      8'h2c:   m.kind = 6'd14;  // ,
      8'h3b:   m.kind = 6'd15;  // ;
      8'h3a:   m.kind = 6'd16;  // :
      8'h2e:   m.kind = 6'd17;  // .
      8'h28:   m.kind = 6'd18;  // (
      8'h29:   m.kind = 6'd19;  // )
      8'h7b:   m.kind = 6'd20;  // {
      8'h7d:   m.kind = 6'd21;  // }
      8'h5b:   m.kind = KIND_LBRACKET;
      8'h5d:   m.kind = KIND_RBRACKET;
      default: begin
        m.hit  = 1'b0;
        m.kind = KIND_NONE;
      end
    endcase
    return m;
  endfunction

  function automatic match_t keyword_match(logic [63:0] w);
    match_t m;
    m.hit  = 1'b0;
    m.kind = KIND_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (w == KEYWORDS[i]) begin
        m.hit  = 1'b1;
        m.kind = KIND_KEYWORD0 + 6'(i);
      end
    end
    return m;
  endfunction

endpackage

/* design/stl_front.sv */
module stl_front import stl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       end_of_source_i,
  input  logic       q_full_i,
  output logic       q_wr_o,
  output entry_t     q_data_o
);

  localparam logic [2:0] MODE_IDLE         = 3'd0;
  localparam logic [2:0] MODE_NUMBER       = 3'd1;
  localparam logic [2:0] MODE_IDENT        = 3'd2;
  localparam logic [2:0] MODE_STRING       = 3'd3;
  localparam logic [2:0] MODE_ERR_UNKNOWN  = 3'd4;
  localparam logic [2:0] MODE_ERR_UNCLOSED = 3'd5;
  localparam logic [2:0] MODE_ERR_OVERFLOW = 3'd6;

  logic [2:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [63:0]            kw_q, kw_d;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_digit, is_alpha, is_space, is_word;
  match_t                 pm, km;
  logic [OFFSET_BITS-1:0] end_ofs, word_len, str_len;
  logic [OFFSET_BITS+15:0] start_ext, word_ext, str_ext, pos_ext;
  result_t                word_res, err_res, new_res;
  logic                   new_valid;
  logic [1:0]             n;
  result_t                r0, r1;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign b          = source_byte_i;

  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  assign is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
  assign is_word  = is_alpha || is_digit || (b == CHAR_UNDERSCORE);
  assign pm       = punct_match(b);
  assign km       = keyword_match(kw_q);

  // a pending word ends at the current offset, whether by a byte or the end marker
  assign end_ofs  = ofs_q;
  assign word_len = end_ofs - start_q;
  assign str_len  = ofs_q - start_q - OFFSET_BITS'(1);

  // low 16 bits of any offset width
  assign start_ext = {16'b0, start_q};
  assign word_ext  = {16'b0, word_len};
  assign str_ext   = {16'b0, str_len};
  assign pos_ext   = {16'b0, ofs_q};

  always_comb begin
    word_res.kind = KIND_NUMBER;
    if (mode_q == MODE_IDENT) begin
      word_res.kind = (km.hit && (word_len <= OFFSET_BITS'(8))) ? km.kind : KIND_IDENT;
    end
    word_res.start = start_ext[15:0];
    word_res.len   = word_ext[15:0];
    word_res.err   = ERR_NONE;
    word_res.last  = 1'b0;
  end

  always_comb begin
    err_res.kind  = KIND_NONE;
    err_res.start = start_ext[15:0];
    err_res.len   = 16'd0;
    err_res.err   = ERR_NONE;
    err_res.last  = 1'b0;
    unique case (mode_q)
      MODE_ERR_UNKNOWN:  err_res.err = ERR_UNKNOWN;
      MODE_ERR_UNCLOSED: err_res.err = ERR_UNCLOSED;
      MODE_ERR_OVERFLOW: err_res.err = ERR_OVERFLOW;
      default:           err_res.err = ERR_NONE;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    ofs_d     = ofs_q;
    start_d   = start_q;
    kw_d      = kw_q;
    n         = 2'd0;
    r0        = word_res;
    r1        = word_res;
    new_valid = 1'b0;
    new_res   = word_res;

    if (mode_q >= MODE_ERR_UNKNOWN) begin
      r0 = err_res;
      n  = 2'd1;
    end else if (end_of_source_i) begin
      if (mode_q == MODE_STRING) begin
        mode_d       = MODE_ERR_UNCLOSED;
        r0           = err_res;
        r0.err       = ERR_UNCLOSED;
        n            = 2'd1;
      end else begin
        if ((mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT)) begin
          n = 2'd1;
        end
        mode_d  = MODE_IDLE;
        ofs_d   = '0;
        start_d = '0;
        kw_d    = '0;
      end
    end else if (ofs_q == '1) begin
      mode_d  = MODE_ERR_OVERFLOW;
      start_d = ofs_q;
      r0      = err_res;
      r0.start = pos_ext[15:0];
      r0.err  = ERR_OVERFLOW;
      n       = 2'd1;
    end else begin
      ofs_d = ofs_q + OFFSET_BITS'(1);
      if (mode_q == MODE_STRING) begin
        if (b == CHAR_QUOTE) begin
          r0.kind = KIND_STRING;
          r0.len  = str_ext[15:0];
          mode_d  = MODE_IDLE;
          n       = 2'd1;
        end
      end else if ((mode_q == MODE_NUMBER) && is_digit) begin
        // number continues
      end else if ((mode_q == MODE_IDENT) && is_word) begin
        kw_d = {kw_q[55:0], b};
      end else begin
        if ((mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT)) begin
          n      = 2'd1;
          mode_d = MODE_IDLE;
        end
        new_res.start = pos_ext[15:0];
        new_res.err   = ERR_NONE;
        if (is_space) begin
          // skipped
        end else if (is_digit) begin
          mode_d  = MODE_NUMBER;
          start_d = ofs_q;
        end else if (b == CHAR_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = ofs_q;
        end else if (is_alpha || (b == CHAR_UNDERSCORE)) begin
          mode_d  = MODE_IDENT;
          start_d = ofs_q;
          kw_d    = {56'b0, b};
        end else if (pm.hit) begin
          new_valid    = 1'b1;
          new_res.kind = pm.kind;
          new_res.len  = 16'd1;
        end else begin
          mode_d       = MODE_ERR_UNKNOWN;
          start_d      = ofs_q;
          new_valid    = 1'b1;
          new_res.kind = KIND_NONE;
          new_res.len  = 16'd0;
          new_res.err  = ERR_UNKNOWN;
        end
        if (new_valid) begin
          if (n == 2'd1) begin
            r1 = new_res;
            n  = 2'd2;
          end else begin
            r0 = new_res;
            n  = 2'd1;
          end
        end
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign q_wr_o        = accept && (n != 2'd0);
  assign q_data_o.two  = (n == 2'd2);
  assign q_data_o.r0   = r0;
  assign q_data_o.r1   = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ofs_q   <= '0;
      start_q <= '0;
      kw_q    <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      ofs_q   <= ofs_d;
      start_q <= start_d;
      kw_q    <= kw_d;
    end
  end

endmodule

/* design/stl_queue.sv */
module stl_queue import stl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  output logic   full_o,
  input  logic   rd_i,
  output entry_t rd_data_o,
  output logic   empty_o
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]   count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (PTR_BITS+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (PTR_BITS+1)'(1);
      end
    end
  end

endmodule

/* design/stl_back.sv */
module stl_back import stl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  entry_t      q_data_i,
  output logic        q_rd_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  entry_t  ent_q;
  logic    have_q, sel_q;
  logic    fire, done, load;
  result_t cur;

  assign fire   = have_q && !out_stall_i;
  // second result pending only when the word produced two
  assign done   = fire && (sel_q || !ent_q.two);
  assign load   = !q_empty_i && (!have_q || done);
  assign q_rd_o = load;

  assign cur            = sel_q ? ent_q.r1 : ent_q.r0;
  assign out_valid_o    = have_q;
  assign token_kind_o   = cur.kind;
  assign start_offset_o = cur.start;
  assign token_length_o = cur.len;
  assign error_code_o   = cur.err;
  assign last_of_run_o  = cur.last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (load) begin
      have_q <= 1'b1;
      sel_q  <= 1'b0;
    end else if (done) begin
      have_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (fire) begin
      sel_q  <= 1'b1;
    end
  end

endmodule

/* design/source_token_lexer_core.sv */
// Channel | Direction | Handshake               | Word
// input   | in        | in_valid_i / in_stall_o | source_byte_i, end_of_source_i
// output  | out       | out_valid_o/out_stall_i | kind, start, length, error, last
//
// One source word is taken per cycle unless the queue is full; its results leave
// one per cycle unless out_stall_i is high. A two-result word holds the output
// stage until both leave; a four-entry queue between the scanner and the output
// register absorbs that and output stalls. in_stall_o rises only when it is full.
// Reset (asynchronous) empties the queue and clears offset, mode and window.
module source_token_lexer_core import stl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  logic   q_full, q_empty, q_wr, q_rd;
  entry_t q_wr_data, q_rd_data;

  stl_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_byte_i  (source_byte_i),
    .end_of_source_i(end_of_source_i),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .q_data_o       (q_wr_data)
  );

  stl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_data_i(q_wr_data),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_data_o(q_rd_data),
    .empty_o  (q_empty)
  );

  stl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rd_data),
    .q_rd_o        (q_rd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .start_offset_o(start_offset_o),
    .token_length_o(token_length_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
